FILE: rtl/pwoa_pkg.sv
// pwoa_pkg: shared constants, types and tables of the phase weighted overlap accumulator
// no dependencies; used by the top level

package pwoa_pkg;

  localparam int MAX_ORBITALS = 8;
  localparam int ACC_WIDTH    = 64;

  localparam int IDX_W   = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;
  localparam int ENTRIES = MAX_ORBITALS * MAX_ORBITALS;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ORBITALS + 1);

  localparam int CORDIC_STEPS  = 40;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int REDUCE_STEPS  = 17;
  localparam int RED_W         = $clog2(REDUCE_STEPS);
  localparam int PHASE_W       = 50;
  localparam int XY_W          = 36;
  localparam int PP_W          = 36;
  localparam int TC_W          = 68;
  localparam int TERM_W        = 40;

  typedef logic signed [PHASE_W-1:0] phase_t;
  typedef phase_t atan_tab_t [CORDIC_STEPS];

  // angles in q.44
  localparam phase_t TWO_PI     = 50'sh6487ED5110B4;
  localparam phase_t ONE_PI     = 50'sh3243F6A8885A;
  localparam phase_t HALF_PI    = 50'sh1921FB54442D;
  localparam phase_t QUARTER_PI = 50'sh0C90FDAA2217;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 36'sh09B74EDA8;

  typedef enum logic [2:0] {
    OP_LOAD_CENTER   = 3'd0,
    OP_LOAD_NEIGHBOR = 3'd1,
    OP_ACCUMULATE    = 3'd2,
    OP_CLEAR         = 3'd3,
    OP_READ          = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_BVEC_X            = 3'd0,
    REG_BVEC_Y            = 3'd1,
    REG_BVEC_Z            = 3'd2,
    REG_GRID_VOLUME       = 3'd3,
    REG_CENTER_ORBITALS   = 3'd4,
    REG_NEIGHBOR_ORBITALS = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PH_MUL,
    ST_PH_ABS,
    ST_PH_REDUCE,
    ST_PH_SUM,
    ST_PH_WRAP,
    ST_PH_FOLD,
    ST_CORDIC,
    ST_ROUND,
    ST_ACC,
    ST_DRAIN,
    ST_RD_DATA,
    ST_RD_MUL,
    ST_RD_SUM,
    ST_RD_OUT
  } state_t;

  // shift-subtract quotient, elaboration only
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent of 2^-i by the integer series in q.62, rounded to q.44
  function automatic atan_tab_t build_atan();
    atan_tab_t         t;
    logic [63:0]        p;
    logic signed [63:0] sum;
    logic signed [63:0] term;
    logic [63:0]        k;
    t[0] = QUARTER_PI;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      p   = 64'd1 << (62 - i);
      sum = '0;
      k   = '0;
      while (p != 64'd0) begin
        term = $signed(long_div(p, 2 * k + 64'd1));
        sum  = k[0] ? sum - term : sum + term;
        if (2 * i >= 63) p = '0;
        else p = p >> (2 * i);
        k = k + 64'd1;
      end
      t[i] = PHASE_W'((sum + 64'sd131072) >>> 18);
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TABLE = build_atan();

endpackage

FILE: rtl/pwoa_if.sv
// pwoa channel interfaces: item input, result output and configuration writes
// depends on nothing but plain logic types

interface pwoa_item_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [2:0]         row_index;
  logic [2:0]         col_index;
  logic signed [31:0] orbital_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, operation, row_index, col_index, orbital_value,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, operation, row_index, col_index, orbital_value,
                pos_x, pos_y, pos_z, output ready);
endinterface

interface pwoa_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] real_part;
  logic signed [63:0] imag_part;
  logic [2:0]         entry_row;
  logic [2:0]         entry_col;
  modport source (output valid, real_part, imag_part, entry_row, entry_col, input ready);
  modport sink (input valid, real_part, imag_part, entry_row, entry_col, output ready);
endinterface

interface pwoa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/phase_weighted_overlap_accumulator.sv
// phase_weighted_overlap_accumulator: load and clear beats complete on acceptance; an accumulate beat
// runs a 3-lane 17-step phase modulo, a wrap, 40 cordic steps, then one accumulator entry per cycle
// through a 3-stage multiply pipeline into the memories; a read beat passes the data, multiply, sum
// and output states, where it can wait on results.ready; one beat is worked at a time
// synchronous reset: config to reset values, all accumulator entries read as zero at once
// depends on pwoa_pkg and the interfaces in pwoa_if.sv

module phase_weighted_overlap_accumulator (
  input  logic            clk,
  input  logic            rst,
  pwoa_item_if.sink       items,
  pwoa_result_if.source   results,
  pwoa_cfg_if.sink        cfg
);

  localparam int MAXO = pwoa_pkg::MAX_ORBITALS;
  localparam int ACCW = pwoa_pkg::ACC_WIDTH;
  localparam int AW   = pwoa_pkg::ADDR_W;
  localparam int IW   = pwoa_pkg::IDX_W;
  localparam int CW   = pwoa_pkg::CNT_W;
  localparam int PW   = pwoa_pkg::PHASE_W;
  localparam int XW   = pwoa_pkg::XY_W;

  // configuration registers
  logic signed [31:0] bvec_x, bvec_y, bvec_z;
  logic [31:0]        grid_volume;
  logic [3:0]         center_orbitals, neighbor_orbitals;

  pwoa_pkg::state_t state, state_next;

  // orbital value stores, undefined until written
  logic signed [31:0] center_vals   [MAXO];
  logic signed [31:0] neighbor_vals [MAXO];

  // accumulator memories plus per-entry valid bits (invalid reads as zero)
  logic signed [ACCW-1:0] acc_re_mem [pwoa_pkg::ENTRIES];
  logic signed [ACCW-1:0] acc_im_mem [pwoa_pkg::ENTRIES];
  logic [pwoa_pkg::ENTRIES-1:0] acc_valid;
  logic [AW-1:0]          rd_addr;
  logic signed [ACCW-1:0] rd_re, rd_im;
  logic                   rd_hit;

  // phase unit
  logic signed [63:0]          ph_prod [3];
  logic [62:0]                 ph_mag  [3];
  logic                        ph_neg  [3];
  logic [pwoa_pkg::RED_W-1:0]  red_cnt;
  pwoa_pkg::phase_t            ph_a;
  logic                        flip;
  logic signed [31:0]          pos_x, pos_y, pos_z;

  // cordic
  logic signed [XW-1:0]        cx, cy;
  logic [pwoa_pkg::STEP_W-1:0] step;
  logic signed [31:0]          cos_v, sin_v;

  // entry iterator and multiply pipeline
  logic [IW-1:0]          it_i, it_j;
  logic [CW-1:0]          nc, nn;
  logic                   last_i, last_j;
  logic                   s1_v, s2_v, s3_v;
  logic [AW-1:0]          s1_addr, s2_addr, s3_addr;
  logic signed [63:0]     s1_prod;
  logic signed [pwoa_pkg::PP_W-1:0] s2_pp;
  logic signed [pwoa_pkg::TC_W-1:0] s3_tc, s3_ts;

  // read path
  logic [2:0]   rd_row, rd_col;
  logic         rd_oob;
  logic [63:0]  rd_mag_re, rd_mag_im;
  logic         rd_neg_re, rd_neg_im;
  logic [63:0]  lo_re, hi_re, lo_im, hi_im;
  logic [64:0]  sum_re, sum_im;

  // decoded controls
  logic         issue;
  logic         out_load;
  logic         accept;
  pwoa_pkg::op_t in_op;
  logic [AW-1:0] in_addr;
  logic         in_oob;

  function automatic logic signed [ACCW-1:0] sat_add(input logic signed [ACCW-1:0] acc,
                                                     input logic signed [pwoa_pkg::TERM_W-1:0] t);
    logic signed [ACCW:0] s;
    s = (ACCW+1)'(acc) + (ACCW+1)'(t);
    if (s[ACCW] != s[ACCW-1]) return s[ACCW] ? {1'b1, {(ACCW-1){1'b0}}} : {1'b0, {(ACCW-1){1'b1}}};
    return s[ACCW-1:0];
  endfunction

  function automatic logic signed [63:0] scale_sat(input logic neg, input logic [64:0] r);
    logic [64:0] lim;
    lim = 65'd1 << 63;
    if (neg) return (r >= lim) ? 64'sh8000_0000_0000_0000 : 64'(65'd0 - r);
    return (r >= lim) ? 64'sh7FFF_FFFF_FFFF_FFFF : r[63:0];
  endfunction

  assign in_op   = pwoa_pkg::op_t'(items.operation);
  assign accept  = items.valid && items.ready;
  assign in_oob  = (int'(items.row_index) >= MAXO) || (int'(items.col_index) >= MAXO);
  assign in_addr = AW'(AW'(items.row_index) * AW'(MAXO) + AW'(items.col_index));

  // orbital counts clamp at the store depth
  assign nc = (int'(center_orbitals) > MAXO) ? CW'(MAXO) : CW'(center_orbitals);
  assign nn = (int'(neighbor_orbitals) > MAXO) ? CW'(MAXO) : CW'(neighbor_orbitals);
  assign last_j = (CW'(it_j) == nn - CW'(1));
  assign last_i = (CW'(it_i) == nc - CW'(1));

  // configuration port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bvec_x            <= '0;
      bvec_y            <= '0;
      bvec_z            <= '0;
      grid_volume       <= '0;
      center_orbitals   <= 4'd1;
      neighbor_orbitals <= 4'd1;
    end else if (cfg.valid && cfg.ready) begin
      case (pwoa_pkg::cfg_reg_t'(cfg.index))
        pwoa_pkg::REG_BVEC_X:            bvec_x <= cfg.data;
        pwoa_pkg::REG_BVEC_Y:            bvec_y <= cfg.data;
        pwoa_pkg::REG_BVEC_Z:            bvec_z <= cfg.data;
        pwoa_pkg::REG_GRID_VOLUME:       grid_volume <= cfg.data;
        pwoa_pkg::REG_CENTER_ORBITALS:   center_orbitals <= cfg.data[3:0];
        pwoa_pkg::REG_NEIGHBOR_ORBITALS: neighbor_orbitals <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pwoa_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_op)
            pwoa_pkg::OP_ACCUMULATE: state_next = pwoa_pkg::ST_PH_MUL;
            pwoa_pkg::OP_READ:       state_next = pwoa_pkg::ST_RD_DATA;
            default:                 state_next = pwoa_pkg::ST_IDLE;
          endcase
        end
      end
      pwoa_pkg::ST_PH_MUL: state_next = pwoa_pkg::ST_PH_ABS;
      pwoa_pkg::ST_PH_ABS: state_next = pwoa_pkg::ST_PH_REDUCE;
      pwoa_pkg::ST_PH_REDUCE: begin
        if (red_cnt == '0) state_next = pwoa_pkg::ST_PH_SUM;
      end
      pwoa_pkg::ST_PH_SUM: state_next = pwoa_pkg::ST_PH_WRAP;
      pwoa_pkg::ST_PH_WRAP: begin
        if (ph_a >= 0 && ph_a < pwoa_pkg::TWO_PI) state_next = pwoa_pkg::ST_PH_FOLD;
      end
      pwoa_pkg::ST_PH_FOLD: state_next = pwoa_pkg::ST_CORDIC;
      pwoa_pkg::ST_CORDIC: begin
        if (step == pwoa_pkg::STEP_W'(pwoa_pkg::CORDIC_STEPS - 1)) state_next = pwoa_pkg::ST_ROUND;
      end
      pwoa_pkg::ST_ROUND: begin
        if (nc == '0 || nn == '0) state_next = pwoa_pkg::ST_IDLE;
        else state_next = pwoa_pkg::ST_ACC;
      end
      pwoa_pkg::ST_ACC: begin
        if (last_i && last_j) state_next = pwoa_pkg::ST_DRAIN;
      end
      pwoa_pkg::ST_DRAIN: begin
        if (!s1_v && !s2_v && !s3_v) state_next = pwoa_pkg::ST_IDLE;
      end
      pwoa_pkg::ST_RD_DATA: state_next = pwoa_pkg::ST_RD_MUL;
      pwoa_pkg::ST_RD_MUL:  state_next = pwoa_pkg::ST_RD_SUM;
      pwoa_pkg::ST_RD_SUM:  state_next = pwoa_pkg::ST_RD_OUT;
      pwoa_pkg::ST_RD_OUT: begin
        if (!results.valid || results.ready) state_next = pwoa_pkg::ST_IDLE;
      end
      default: state_next = pwoa_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    items.ready = (state == pwoa_pkg::ST_IDLE);
    issue       = (state == pwoa_pkg::ST_ACC);
    out_load    = (state == pwoa_pkg::ST_RD_OUT) && (!results.valid || results.ready);
    // idle: address of an incoming read, otherwise the pipeline entry about to be summed
    rd_addr     = (state == pwoa_pkg::ST_IDLE) ? in_addr : s2_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pwoa_pkg::ST_IDLE;
    else state <= state_next;
  end

  // loads into the orbital stores; loads beyond the store are dropped
  always_ff @(posedge clk) begin
    if (accept && !(int'(items.row_index) >= MAXO)) begin
      if (in_op == pwoa_pkg::OP_LOAD_CENTER) center_vals[IW'(items.row_index)] <= items.orbital_value;
      if (in_op == pwoa_pkg::OP_LOAD_NEIGHBOR)
        neighbor_vals[IW'(items.row_index)] <= items.orbital_value;
    end
  end

  // phase: b.r per axis, remainder mod 2pi by 17 restoring steps, then wrap and fold
  always_ff @(posedge clk) begin
    if (accept && in_op == pwoa_pkg::OP_ACCUMULATE) begin
      pos_x <= items.pos_x;
      pos_y <= items.pos_y;
      pos_z <= items.pos_z;
    end
    case (state)
      pwoa_pkg::ST_PH_MUL: begin
        ph_prod[0] <= bvec_x * pos_x;
        ph_prod[1] <= bvec_y * pos_y;
        ph_prod[2] <= bvec_z * pos_z;
        red_cnt    <= pwoa_pkg::RED_W'(pwoa_pkg::REDUCE_STEPS - 1);
      end
      pwoa_pkg::ST_PH_ABS: begin
        for (int k = 0; k < 3; k++) begin
          ph_neg[k] <= ph_prod[k][63];
          ph_mag[k] <= ph_prod[k][63] ? 63'(64'sd0 - ph_prod[k]) : ph_prod[k][62:0];
        end
      end
      pwoa_pkg::ST_PH_REDUCE: begin
        for (int k = 0; k < 3; k++) begin
          if (ph_mag[k] >= (63'(pwoa_pkg::TWO_PI) << red_cnt))
            ph_mag[k] <= ph_mag[k] - (63'(pwoa_pkg::TWO_PI) << red_cnt);
        end
        red_cnt <= red_cnt - pwoa_pkg::RED_W'(1);
      end
      pwoa_pkg::ST_PH_SUM: begin
        // remainders keep the sign of the product; the sum is negated
        ph_a <= PW'(0) - ((ph_neg[0] ? -PW'(ph_mag[0]) : PW'(ph_mag[0]))
                        + (ph_neg[1] ? -PW'(ph_mag[1]) : PW'(ph_mag[1]))
                        + (ph_neg[2] ? -PW'(ph_mag[2]) : PW'(ph_mag[2])));
      end
      pwoa_pkg::ST_PH_WRAP: begin
        if (ph_a < 0) ph_a <= ph_a + pwoa_pkg::TWO_PI;
        else if (ph_a >= pwoa_pkg::TWO_PI) ph_a <= ph_a - pwoa_pkg::TWO_PI;
        else if (ph_a > pwoa_pkg::ONE_PI) ph_a <= ph_a - pwoa_pkg::TWO_PI;
      end
      pwoa_pkg::ST_PH_FOLD: begin
        // fold into [-pi/2, pi/2]; cos and sin change sign
        if (ph_a > pwoa_pkg::HALF_PI) begin
          ph_a <= ph_a - pwoa_pkg::ONE_PI;
          flip <= 1'b1;
        end else if (ph_a < -pwoa_pkg::HALF_PI) begin
          ph_a <= ph_a + pwoa_pkg::ONE_PI;
          flip <= 1'b1;
        end else begin
          flip <= 1'b0;
        end
        cx <= pwoa_pkg::CORDIC_GAIN;
        cy <= '0;
      end
      pwoa_pkg::ST_CORDIC: begin
        // one rotation step per cycle
        if (ph_a >= 0) begin
          cx   <= cx - (cy >>> step);
          cy   <= cy + (cx >>> step);
          ph_a <= ph_a - pwoa_pkg::ATAN_TABLE[step];
        end else begin
          cx   <= cx + (cy >>> step);
          cy   <= cy - (cx >>> step);
          ph_a <= ph_a + pwoa_pkg::ATAN_TABLE[step];
        end
      end
      pwoa_pkg::ST_ROUND: begin
        cos_v <= 32'(((flip ? -cx : cx) + XW'(8)) >>> 4);
        sin_v <= 32'(((flip ? -cy : cy) + XW'(8)) >>> 4);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == pwoa_pkg::ST_CORDIC) begin
      step <= step + pwoa_pkg::STEP_W'(1);
    end else begin
      step <= '0;
    end
  end

  // entry iterator, row-major over the orbitals in use
  always_ff @(posedge clk) begin
    if (rst) begin
      it_i <= '0;
      it_j <= '0;
    end else if (issue) begin
      if (last_j) begin
        it_j <= '0;
        it_i <= last_i ? '0 : it_i + IW'(1);
      end else begin
        it_j <= it_j + IW'(1);
      end
    end
  end

  // multiply pipeline: chi*phi, rounded product, times cos/sin, then summed into memory
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod <= center_vals[it_i] * neighbor_vals[it_j];
    s1_addr <= AW'(AW'(it_i) * AW'(MAXO) + AW'(it_j));
    s2_pp   <= pwoa_pkg::PP_W'((s1_prod + 64'sd134217728) >>> 28);
    s2_addr <= s1_addr;
    s3_tc   <= s2_pp * cos_v;
    s3_ts   <= s2_pp * sin_v;
    s3_addr <= s2_addr;
  end

  // accumulator memories: one read and one write port
  always_ff @(posedge clk) begin
    rd_re  <= acc_re_mem[rd_addr];
    rd_im  <= acc_im_mem[rd_addr];
    rd_hit <= acc_valid[rd_addr];
    if (s3_v) begin
      acc_re_mem[s3_addr] <= sat_add(rd_hit ? rd_re : '0,
                                     pwoa_pkg::TERM_W'((s3_tc + 68'sd134217728) >>> 28));
      acc_im_mem[s3_addr] <= sat_add(rd_hit ? rd_im : '0,
                                     pwoa_pkg::TERM_W'((s3_ts + 68'sd134217728) >>> 28));
    end
  end

  // valid bits; a clear drops them all at once
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
    end else if (accept && in_op == pwoa_pkg::OP_CLEAR) begin
      acc_valid <= '0;
    end else if (s3_v) begin
      acc_valid[s3_addr] <= 1'b1;
    end
  end

  // read: magnitude, two 32x32 halves against the volume, round, saturate
  always_ff @(posedge clk) begin
    logic signed [63:0] v_re, v_im;
    v_re = (rd_hit && !rd_oob) ? 64'(rd_re) : '0;
    v_im = (rd_hit && !rd_oob) ? 64'(rd_im) : '0;
    if (accept && in_op == pwoa_pkg::OP_READ) begin
      rd_row <= items.row_index;
      rd_col <= items.col_index;
      rd_oob <= in_oob;
    end
    if (state == pwoa_pkg::ST_RD_DATA) begin
      rd_neg_re <= v_re[63];
      rd_neg_im <= v_im[63];
      rd_mag_re <= v_re[63] ? 64'(64'sd0 - v_re) : 64'(v_re);
      rd_mag_im <= v_im[63] ? 64'(64'sd0 - v_im) : 64'(v_im);
    end
    lo_re  <= rd_mag_re[31:0] * grid_volume;
    hi_re  <= rd_mag_re[63:32] * grid_volume;
    lo_im  <= rd_mag_im[31:0] * grid_volume;
    hi_im  <= rd_mag_im[63:32] * grid_volume;
    sum_re <= {1'b0, hi_re} + 65'((lo_re + 64'h8000_0000) >> 32);
    sum_im <= {1'b0, hi_im} + 65'((lo_im + 64'h8000_0000) >> 32);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.real_part <= scale_sat(rd_neg_re, sum_re);
      results.imag_part <= scale_sat(rd_neg_im, sum_im);
      results.entry_row <= rd_row;
      results.entry_col <= rd_col;
    end
  end

  // memory writes happen only while an accumulate pass runs
  a_write_in_pass: assert property (@(posedge clk) disable iff (rst)
    s3_v |-> (state == pwoa_pkg::ST_ACC || state == pwoa_pkg::ST_DRAIN))
    else $error("accumulator write outside an accumulate pass");

  // a new beat is taken only with the pipeline empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> (!s1_v && !s2_v && !s3_v))
    else $error("input ready while pipeline busy");

  // a result appears only from the read path
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == pwoa_pkg::ST_RD_OUT)
    else $error("result valid without a read");

  // reset leaves every entry reading as zero
  a_reset_clears: assert property (@(posedge clk) rst |=> acc_valid == '0)
    else $error("valid bits not cleared by reset");

  // rotation count stays within the table
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == pwoa_pkg::ST_CORDIC |-> step < pwoa_pkg::STEP_W'(pwoa_pkg::CORDIC_STEPS))
    else $error("cordic step beyond table");

endmodule
